// ===== sv/kfei_pkg.sv =====
// Package for the keyframe ease interpolator: payload structs, commands, FSM states.
// No dependencies.
package kfei_pkg;

  localparam int unsigned MaxKeys = 16;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = 5;

  typedef enum logic [1:0] {
    CmdAdvance  = 2'd0,
    CmdWrite    = 2'd1,
    CmdSetTime  = 2'd2,
    CmdSetSeg   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] delta_time;
    logic [3:0]  entry_index;
    logic [31:0] entry_time;
    logic signed [31:0] entry_value;
    logic [31:0] new_time;
    logic [3:0]  new_segment;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [3:0]  segment_out;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StRdLast,
    StWrap,
    StModRun,
    StRdWalk,
    StWalk,
    StRdSeg,
    StDivRun,
    StEase,
    StMul,
    StFinish,
    StOut
  } state_e;

endpackage

// ===== sv/kfei_divu.sv =====
// Restoring divider, one quotient bit per cycle: 64-bit dividend, 32-bit divisor.
// No dependencies; kfei_pkg is not used here.
module kfei_divu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [31:0] rem_o
);
  logic [63:0] q_q, q_d;
  logic [32:0] r_q, r_d;
  logic [31:0] d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;

  always_comb begin
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {r_q[31:0], q_q[63]} - {1'b0, d_q};
    if (start_i) begin
      q_d = dividend_i; r_d = '0; d_d = divisor_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        r_d = trial;
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = {r_q[31:0], q_q[63]};
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quot_o = q_d;
  assign rem_o  = r_d[31:0];
endmodule

// ===== sv/kfei_key_ram.sv =====
// Keyframe table: time and value in one synchronous RAM, one read port, one write port.
// Depends on kfei_pkg.
module kfei_key_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [kfei_pkg::IdxW-1:0] waddr_i,
  input  logic [63:0]               wdata_i,
  input  logic [kfei_pkg::IdxW-1:0] raddr_i,
  output logic [63:0]               rdata_o
);
  import kfei_pkg::*;
  logic [63:0] mem [MaxKeys];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/keyframe_ease_interpolator_top.sv =====
// Keyframe ease interpolator top level. Uses kfei_pkg, kfei_key_ram, kfei_divu.
// Advance commands use up to two divider passes (wrap modulo, normalized t) plus up
//   to 17 table reads of the walk.
// Throughput: one item at a time; the next is taken once the previous result is loaded
//   into the result register, which holds it while the receiver stalls.
// Reset: time, segment, value cleared, key_count = 2; table contents undefined until written.
module keyframe_ease_interpolator_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kfei_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kfei_pkg::out_item_t  out_data_o
);
  import kfei_pkg::*;

  state_e state_q, state_d;
  logic [4:0]  cnt_cfg_q;
  logic [4:0]  n_c;
  logic [31:0] time_q, time_d;
  logic [IdxW-1:0] seg_q, seg_d, nxt_q, nxt_d;
  logic signed [31:0] val_q, val_d;
  logic [4:0]  steps_q, steps_d;
  logic [32:0] sum_q, sum_d;
  logic signed [31:0] vseg_q, vseg_d;
  logic [31:0] tnxt_q, tnxt_d;
  logic signed [31:0] vnxt_q, vnxt_d;
  logic [16:0] t_q, t_d;
  logic [16:0] e_q, e_d;
  logic signed [49:0] prod_q, prod_d;
  logic        rd_sel_q, rd_sel_d;
  out_item_t   out_q, out_d;
  logic        ov_q, ov_d;

  logic        we;
  logic [IdxW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata;
  logic        dstart, ddone;
  logic [63:0] dnum, dquot;
  logic [31:0] dden, drem;
  logic [31:0] rtime;
  logic signed [31:0] rval;
  logic [33:0] tt;
  logic [32:0] diff, span;
  logic signed [32:0] dv;

  kfei_key_ram u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  kfei_divu u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart), .dividend_i(dnum),
    .divisor_i(dden), .done_o(ddone), .quot_o(dquot), .rem_o(drem)
  );

  assign rtime = rdata[63:32];
  assign rval  = rdata[31:0];
  assign n_c = (cnt_cfg_q < 5'd2) ? 5'd2 :
               (cnt_cfg_q > 5'(MaxKeys)) ? 5'(MaxKeys) : cnt_cfg_q;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  function automatic logic [IdxW-1:0] inc_mod(logic [IdxW-1:0] s, logic [4:0] n);
    logic [4:0] x;
    x = {1'b0, s} + 5'd1;
    return (x >= n) ? '0 : x[IdxW-1:0];
  endfunction

  always_comb begin
    state_d = state_q; time_d = time_q; seg_d = seg_q; nxt_d = nxt_q; val_d = val_q;
    steps_d = steps_q; sum_d = sum_q; vseg_d = vseg_q;
    tnxt_d = tnxt_q; vnxt_d = vnxt_q; t_d = t_q; e_d = e_q; prod_d = prod_q;
    rd_sel_d = rd_sel_q; out_d = out_q; ov_d = ov_q;
    we = 1'b0; waddr = in_data_i.entry_index; wdata = {in_data_i.entry_time,
                                                      in_data_i.entry_value};
    raddr = nxt_q; dstart = 1'b0; dnum = '0; dden = tnxt_q;
    diff = '0; span = '0; tt = '0; dv = '0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          case (cmd_e'(in_data_i.command))
            CmdAdvance: begin
              sum_d = {1'b0, time_q} + {1'b0, in_data_i.delta_time};
              if ({1'b0, seg_q} >= n_c) seg_d = '0;
              raddr = IdxW'(n_c - 5'd1);
              state_d = StRdLast;
            end
            CmdWrite: begin
              we = 1'b1;
              state_d = StOut;
            end
            CmdSetTime: begin
              time_d = in_data_i.new_time;
              state_d = StOut;
            end
            default: begin
              seg_d = in_data_i.new_segment;
              state_d = StOut;
            end
          endcase
        end
      end
      StRdLast: begin
        raddr = IdxW'(n_c - 5'd1);
        state_d = StWrap;
      end
      StWrap: begin
        tnxt_d = rtime;
        if (sum_q >= {1'b0, rtime}) begin
          seg_d = '0;
          if (rtime == '0) begin
            time_d = '0;
            state_d = StRdWalk;
          end else begin
            dstart = 1'b1;
            dnum = {31'd0, sum_q};
            dden = rtime;
            state_d = StModRun;
          end
        end else begin
          time_d = sum_q[31:0];
          state_d = StRdWalk;
        end
        steps_d = '0;
      end
      StModRun: if (ddone) begin
        time_d = drem;
        state_d = StRdWalk;
      end
      StRdWalk: begin
        if (steps_q == '0) nxt_d = inc_mod(seg_q, n_c);
        state_d = StWalk;
      end
      StWalk: begin
        raddr = nxt_q;
        state_d = StRdSeg;
        rd_sel_d = 1'b0;
      end
      StRdSeg: begin
        if (!rd_sel_q) begin
          tnxt_d = rtime; vnxt_d = rval;
          if (rtime < time_q && steps_q < n_c) begin
            seg_d = nxt_q;
            nxt_d = inc_mod(nxt_q, n_c);
            steps_d = steps_q + 5'd1;
            state_d = StWalk;
          end else begin
            raddr = seg_q;
            rd_sel_d = 1'b1;
            state_d = StDivRun;
          end
        end
      end
      StDivRun: begin
        if (rd_sel_q) begin
          rd_sel_d = 1'b0;
          vseg_d = rval;
          diff = {1'b0, time_q} - {1'b0, rtime};
          span = {1'b0, tnxt_q} - {1'b0, rtime};
          if (span[32] || span == '0 || diff[32] || diff == '0) begin
            t_d = '0; state_d = StEase;
          end else if (diff >= span) begin
            t_d = 17'h10000; state_d = StEase;
          end else begin
            dstart = 1'b1;
            dnum = {16'd0, diff[31:0], 16'd0};
            dden = span[31:0];
          end
        end else if (ddone) begin
          t_d = dquot[16:0];
          state_d = StEase;
        end
      end
      StEase: begin
        tt = 34'(t_q) * (34'd131072 - 34'(t_q));
        e_d = tt[32:16];
        state_d = StMul;
      end
      StMul: begin
        dv = 33'(vnxt_q) - 33'(vseg_q);
        prod_d = 50'(dv) * $signed({33'd0, e_q});
        state_d = StFinish;
      end
      StFinish: begin
        val_d = vseg_q + 32'(prod_q >>> 16);
        state_d = StOut;
      end
      default: begin
        if (!ov_q || out_ready_i) begin
          out_d.value_out = val_q;
          out_d.segment_out = seg_q;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_cfg_q <= 5'd2; time_q <= '0; seg_q <= '0;
      val_q <= '0; ov_q <= 1'b0; steps_q <= '0; rd_sel_q <= 1'b0;
    end else begin
      state_q <= state_d; time_q <= time_d; seg_q <= seg_d; val_q <= val_d;
      ov_q <= ov_d; steps_q <= steps_d; rd_sel_q <= rd_sel_d;
      if (cfg_we_i) cnt_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q <= nxt_d; sum_q <= sum_d; vseg_q <= vseg_d;
    tnxt_q <= tnxt_d; vnxt_q <= vnxt_d; t_q <= t_d; e_q <= e_d;
    prod_q <= prod_d; out_q <= out_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == StIdle)) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q) else $error("result dropped");
  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEase) |-> (t_q <= 17'h10000)) else $error("t out of range");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> (steps_q <= 5'(MaxKeys))) else $error("walk overrun");
endmodule

// ===== tb/keyframe_ease_interpolator_top_test.sv =====
// Self-checking bench for keyframe_ease_interpolator_top: a directed table, then random phases.
// Uses kfei_pkg for the payload types and command codes; predicts each result in place or takes it from the table.
module keyframe_ease_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kfei_pkg::*;

  localparam int unsigned WatchLimit = 6000;
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned InBits = $bits(in_item_t);

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  keyframe_ease_interpolator_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block's state.
  logic [31:0]        key_time_m [MaxKeys];
  logic signed [31:0] key_value_m [MaxKeys];
  logic [31:0]        run_time_m = '0;
  logic [3:0]         segment_m = '0;
  logic signed [31:0] value_m = '0;
  logic [4:0]         key_count_m = 5'd2;

  out_item_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit calm = 1'b0;
  int unsigned key_step;

  function automatic void ease_advance(logic [31:0] dt);
    int unsigned n, s, nx, i;
    longint unsigned sum, last;
    longint diff, span, t, e, dv;
    n = key_count_m < 2 ? 2 : (key_count_m > MaxKeys ? MaxKeys : key_count_m);
    sum = longint'(run_time_m) + longint'(dt);
    last = key_time_m[n-1];
    s = segment_m;
    if (s >= n) s = 0;
    if (sum >= last) begin
      s = 0;
      sum = (last == 0) ? 0 : sum % last;
    end
    run_time_m = sum[31:0];
    nx = (s + 1) % n;
    for (i = 0; i < n && key_time_m[nx] < run_time_m; i++) begin
      s = nx;
      nx = (s + 1) % n;
    end
    segment_m = s[3:0];
    diff = longint'(run_time_m) - longint'(key_time_m[s]);
    span = longint'(key_time_m[nx]) - longint'(key_time_m[s]);
    if (span <= 0 || diff <= 0) t = 0;
    else if (diff >= span) t = 65536;
    else t = (diff * 65536) / span;
    e = (t * (131072 - t)) / 65536;
    dv = longint'(key_value_m[nx]) - longint'(key_value_m[s]);
    value_m = 32'(longint'(key_value_m[s]) + ((dv * e) >>> 16));
  endfunction

  function automatic out_item_t ease_model_step(in_item_t it);
    out_item_t r;
    case (cmd_e'(it.command))
      CmdAdvance: ease_advance(it.delta_time);
      CmdWrite: begin
        key_time_m[it.entry_index]  = it.entry_time;
        key_value_m[it.entry_index] = it.entry_value;
      end
      CmdSetTime: run_time_m = it.new_time;
      default: segment_m = it.new_segment;
    endcase
    r.value_out = value_m;
    r.segment_out = segment_m;
    return r;
  endfunction

  function automatic in_item_t noise_item(cmd_e c);
    in_item_t it;
    it = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.command = c;
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_result);
    out_item_t r;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    r = ease_model_step(it);
    pending_results.push_back(typed ? typed_result : r);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_key_count(logic [4:0] v);
    drain_and_settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    key_count_m = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t ordered_write(int unsigned idx);
    in_item_t it;
    it = noise_item(CmdWrite);
    it.entry_index = idx[3:0];
    it.entry_time = idx * key_step + ($urandom_range(3) == 0 ? $urandom_range(0, key_step / 4) : 0);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      it = noise_item(CmdAdvance);
      it.delta_time = (pick < 50) ? $urandom_range(0, 2 * key_step + 1) : $urandom;
    end else if (pick < 75) begin
      it = ordered_write($urandom_range(MaxKeys - 1));
      if (pick < 59) it.entry_time = $urandom;
    end else if (pick < 88) begin
      it = noise_item(CmdSetTime);
      if (pick < 85) it.new_time = $urandom_range(0, MaxKeys * key_step);
    end else begin
      it = noise_item(CmdSetSeg);
    end
    return it;
  endfunction

  // Receiver stall bursts.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: %p", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (want.value_out !== out_data_o.value_out ||
            want.segment_out !== out_data_o.segment_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d seg %0d, got value %0d seg %0d",
                     want.value_out, want.segment_out,
                     out_data_o.value_out, out_data_o.segment_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    logic [4:0] counts[10];
    int unsigned p, k;
    for (k = 0; k < MaxKeys; k++) begin
      key_time_m[k] = '0;
      key_value_m[k] = '0;
    end
    key_step = 32'h0001_0000;
    counts = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd3, 5'd9, 5'd16, 5'd5, 5'd12};
    counts[8] = 5'($urandom_range(2, 16));
    counts[9] = 5'($urandom);

    row.item = noise_item(CmdSetTime); row.item.new_time = '1;
    row.typed = 1; row.result = '{32'sd0, 4'd0}; rows.push_back(row);
    row.item = noise_item(CmdSetSeg); row.item.new_segment = 4'hf;
    row.typed = 1; row.result = '{32'sd0, 4'hf}; rows.push_back(row);
    row.typed = 0;
    for (k = 0; k < MaxKeys; k++) begin
      row.item = ordered_write(k);
      row.item.entry_value = (k % 2) ? 32'h7fff_ffff : 32'h8000_0000;
      if (k == 3) row.item.entry_time = 32'h0002_0000;
      rows.push_back(row);
    end
    row.item = noise_item(CmdAdvance); row.item.delta_time = '0; rows.push_back(row);
    row.item.delta_time = 32'h0000_8000; rows.push_back(row);
    row.item.delta_time = '1; rows.push_back(row);
    row.item = noise_item(CmdSetTime); row.item.new_time = 32'h0000_4000; rows.push_back(row);
    row.item = noise_item(CmdAdvance); row.item.delta_time = 32'h0000_4000; rows.push_back(row);
    row.item = noise_item(CmdSetSeg); row.item.new_segment = '0; rows.push_back(row);
    row.item = noise_item(CmdAdvance); row.item.delta_time = 32'h0001_0000; rows.push_back(row);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);

    for (p = 0; p < 10; p++) begin
      write_key_count(counts[p]);
      calm = (p == 9);
      case (p % 4)
        0: key_step = 32'h0001_0000;
        1: key_step = $urandom_range(1, 32'h0800_0000);
        2: key_step = $urandom_range(0, 4);
        default: key_step = $urandom_range(16, 4096);
      endcase
      for (k = 0; k < MaxKeys; k++) send_item(ordered_write(k), 0, '0);
      for (k = 0; k < 45; k++) begin
        if (p == 4 && k == 20) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
        end
        send_item(random_item(), 0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
